// ===== rtl/integer_to_ascii_radix_macros.svh =====
// assertion macros for the integer to ascii radix converter
// used by the rtl files that carry concurrent assertions, no other dependencies
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ITAR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("itar assertion failed");

// antecedent implies consequent in the next cycle
`define ITAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("itar assertion failed");

`else

`define ITAR_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ITAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/itar_pkg.sv =====
// types, codes and constants for the integer to ascii radix converter
// no dependencies; used by itar_step and integer_to_ascii_radix
`timescale 1ns / 1ps

package itar_pkg;

    // format selector codes
    localparam logic [2:0] FUNC_SDEC  = 3'd0;
    localparam logic [2:0] FUNC_UDEC  = 3'd1;
    localparam logic [2:0] FUNC_LHEX  = 3'd2;
    localparam logic [2:0] FUNC_UHEX  = 3'd3;
    localparam logic [2:0] FUNC_HEX0X = 3'd4;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    // divide by ten through reciprocal multiply
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // text buffer: sign plus ten decimal digits
    localparam int BUF_DEPTH = 11;
    localparam int BUF_AW    = 4;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  func;
    } t_in_word;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_word;

    // result of one divide step
    typedef struct packed {
        logic [31:0] quot;
        logic [3:0]  digit;
    } t_step;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_TAIL,
        ST_EMIT
    } t_state;

    // digit value to ascii character
    function automatic logic [7:0] digit_to_ascii(input logic [3:0] digit, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (digit < 4'd10) begin
            return CH_ZERO + {4'b0, digit};
        end
        return base + {4'b0, digit} - 8'd10;
    endfunction

endpackage

// ===== rtl/integer_to_ascii_radix.sv =====
// top level of the integer to ascii radix converter
// depends on itar_pkg, itar_step and integer_to_ascii_radix_macros.svh
`timescale 1ns / 1ps
`include "integer_to_ascii_radix_macros.svh"

// Converts one 32-bit value to ASCII text (signed or unsigned decimal, lower or
// upper hex, or 0x-prefixed hex) and sends it one character per output word,
// most significant character first, with last set on the final character.
// Selector codes 5 to 7 are taken and give no output. A single divide step unit
// peels one digit per cycle into a small text buffer, the sign or prefix is
// appended in one cycle per character, and the buffer is then read back one
// character per cycle while the output is not stalled. o_stall stays high from
// the item's acceptance until its last character has been loaded for output,
// so the next item waits for that; i_stall on the output stretches the readout.

module integer_to_ascii_radix import itar_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_word,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_word o_word,
    input  logic      i_stall
);

    t_state      r_state, n_state;
    logic [31:0] r_value, n_value;
    logic        r_hex, n_hex;
    logic        r_upper, n_upper;
    logic [1:0]  r_pend, n_pend;
    logic [3:0]  r_wp, n_wp;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;
    logic [7:0]  r_buf [BUF_DEPTH];

    logic        wr_en;
    logic [7:0]  wr_char;
    logic [BUF_AW-1:0] rd_idx;
    logic        load_ok;
    logic        in_neg;
    t_step       step;

    // shared divide unit
    itar_step u_step (
        .i_value (r_value),
        .i_hex   (r_hex),
        .o_step  (step)
    );

    assign rd_idx  = r_wp - 4'd1;
    assign load_ok = !r_out_valid || !i_stall;
    assign in_neg  = (i_word.func == FUNC_SDEC) && i_word.value[31];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_hex       = r_hex;
        n_upper     = r_upper;
        n_pend      = r_pend;
        n_wp        = r_wp;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_char     = CH_ZERO;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_word.func <= FUNC_HEX0X) begin
                    n_state = ST_DIV;
                    n_value = in_neg ? (~i_word.value + 32'd1) : i_word.value;
                    n_hex   = (i_word.func >= FUNC_LHEX);
                    n_upper = (i_word.func == FUNC_UHEX);
                    n_wp    = 4'd0;
                    if (in_neg) begin
                        n_pend = 2'd1;
                    end else if (i_word.func == FUNC_HEX0X) begin
                        n_pend = 2'd2;
                    end else begin
                        n_pend = 2'd0;
                    end
                end
            end
            ST_DIV: begin
                wr_en   = 1'b1;
                wr_char = digit_to_ascii(step.digit, r_upper);
                n_wp    = r_wp + 4'd1;
                n_value = step.quot;
                if (step.quot == 32'd0) begin
                    n_state = (r_pend != 2'd0) ? ST_TAIL : ST_EMIT;
                end
            end
            ST_TAIL: begin
                // prefix goes in reversed, buffer is read top down
                wr_en   = 1'b1;
                wr_char = !r_hex ? CH_MINUS : ((r_pend == 2'd2) ? CH_X : CH_ZERO);
                n_wp    = r_wp + 4'd1;
                n_pend  = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_ok) begin
                    n_out_valid     = 1'b1;
                    n_out.character = r_buf[rd_idx];
                    n_out.last      = (r_wp == 4'd1);
                    n_wp            = r_wp - 4'd1;
                    if (r_wp == 4'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 2'd0;
            r_wp        <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_wp        <= n_wp;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_hex   <= n_hex;
        r_upper <= n_upper;
        r_out   <= n_out;
        if (wr_en) begin
            r_buf[r_wp] <= wr_char;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // checks
    `ITAR_ASSERT_SAME(a_wp_range, i_clk, i_rst_n, 1'b1, r_wp <= 4'd11)
    `ITAR_ASSERT_SAME(a_emit_nonempty, i_clk, i_rst_n, r_state == ST_EMIT, r_wp != 4'd0)
    `ITAR_ASSERT_SAME(a_div_room, i_clk, i_rst_n, r_state == ST_DIV, r_wp < 4'd10)
    `ITAR_ASSERT_NEXT(a_start_div, i_clk, i_rst_n, i_valid && !o_stall && i_word.func <= FUNC_HEX0X, r_state == ST_DIV)

endmodule

// ===== rtl/itar_step.sv =====
// shared divide step: one digit off the bottom of the value per call
// depends on itar_pkg
`timescale 1ns / 1ps

module itar_step import itar_pkg::*; (
    input  logic [31:0] i_value,
    input  logic        i_hex,
    output t_step       o_step
);

    logic [63:0] prod;
    logic [31:0] dec_quot;
    logic [3:0]  q_times10;

    // quotient by ten through the reciprocal
    assign prod     = 64'(i_value) * 64'(RECIP_10);
    assign dec_quot = 32'(prod >> RECIP_SHIFT);

    // remainder is below ten, so the low nibble of v - 10q is enough
    assign q_times10 = {dec_quot[0], 3'b000} + {dec_quot[2:0], 1'b0};

    // radix select
    always_comb begin
        if (i_hex) begin
            o_step.quot  = {4'b0, i_value[31:4]};
            o_step.digit = i_value[3:0];
        end else begin
            o_step.quot  = dec_quot;
            o_step.digit = i_value[3:0] - q_times10;
        end
    end

endmodule
